[sv/assert_macros.svh]
// Assertion macros for the format string number expander.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside of reset.
`define FSNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FSNE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/fsne_pkg.sv]
// Package with constants, types and helpers of the format string number expander.
package fsne_pkg;

  localparam int DecimalDigitsDefault = 5;
  localparam int HexDigits            = 8;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharDec     = 8'h64;
  localparam logic [7:0] CharHex     = 8'h78;
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharUpperA  = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PCT_CHAR,
    ST_CONV,
    ST_DIGIT,
    ST_HEX_X,
    ST_HEX
  } fsne_state_e;

  function automatic logic [63:0] pow10(input int d);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < d; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

[sv/format_string_number_expander_unit.sv]
// Top level of the format string number expander: character stream to glyph codes.
//
// One format character is taken per transaction and expanded into zero to ten
// character codes, one per cycle through a single output register while it is
// taken. A plain character gives itself; a bare '%' gives no code but marks the
// following character. A '%' followed by any character other than 'd' or 'x'
// gives '%' and that character. "%x" gives "0x" and eight upper-case hex digits.
// "%d" of zero gives '0'. "%d" of a nonzero value gives '-' if negative; then the
// clamped magnitude, W = ceil(log2(10^DECIMAL_DIGITS)) bits capped at 32, is
// converted to BCD one bit per cycle by a shift-and-add-3 loop, then the digits
// are shifted out one per cycle, suppressed leading zeros included, each sent
// digit waiting while the output register is full and not taken.
`include "assert_macros.svh"

module format_string_number_expander_unit #(
  parameter int DECIMAL_DIGITS = fsne_pkg::DecimalDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  fmt_char_i,
  input  logic [31:0] argument_i,
  input  logic        start_of_string_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  char_code_o,
  output logic        last_in_run_o
);

  localparam logic [63:0] Limit    = fsne_pkg::pow10(DECIMAL_DIGITS) - 64'd1;
  localparam logic [63:0] NegLimit = (Limit > 64'd999999999) ? 64'd999999999 : Limit;
  localparam logic [63:0] PosLimit = (Limit > 64'hFFFFFFFF) ? 64'hFFFFFFFF : Limit;
  localparam logic [31:0] PosLim32 = PosLimit[31:0];
  localparam logic [31:0] NegLim32 = NegLimit[31:0];
  localparam int LimBits = $clog2(Limit + 64'd1);
  localparam int MagW    = (LimBits > 32) ? 32 : LimBits;
  localparam int BcdW    = DECIMAL_DIGITS * 4;
  localparam int CntMax0 = (MagW > DECIMAL_DIGITS) ? MagW : DECIMAL_DIGITS;
  localparam int CntMax  = (CntMax0 > fsne_pkg::HexDigits) ? CntMax0 : fsne_pkg::HexDigits;
  localparam int CntW    = $clog2(CntMax + 1);

  fsne_pkg::fsne_state_e state_q, state_d;

  logic [31:0]     saved_q, saved_d;
  logic [31:0]     rem_q, rem_d;
  logic            pend_q, pend_d;
  logic [7:0]      hold_q, hold_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [31:0]     hex_q, hex_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            dstart_q, dstart_d;
  logic            ovalid_q, ovalid_d;
  logic [7:0]      char_q, char_d;
  logic            last_q, last_d;

  logic            can_load;
  logic            in_fire;
  logic [31:0]     saved_eff, rem_eff, mag_abs, mag_lim, mag_clamp;
  logic            pend_eff;
  logic [BcdW-1:0] bcd_adj;
  logic [3:0]      top_dig, nib;
  logic            busy;
  logic            dig_end;

  assign can_load   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == fsne_pkg::ST_IDLE) && can_load;
  assign in_fire    = in_valid_i && in_ready_o;

  assign saved_eff = start_of_string_i ? argument_i : saved_q;
  assign rem_eff   = start_of_string_i ? argument_i : rem_q;
  assign pend_eff  = start_of_string_i ? 1'b0 : pend_q;
  assign mag_abs   = rem_eff[31] ? (~rem_eff + 32'd1) : rem_eff;
  assign mag_lim   = rem_eff[31] ? NegLim32 : PosLim32;
  assign mag_clamp = (mag_abs > mag_lim) ? mag_lim : mag_abs;

  always_comb begin
    for (int i = 0; i < DECIMAL_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? (bcd_q[i*4 +: 4] + 4'd3)
                                                     : bcd_q[i*4 +: 4];
    end
  end

  assign top_dig = bcd_q[BcdW-1 -: 4];
  assign nib     = hex_q[31:28];

  always_comb begin
    state_d  = state_q;
    saved_d  = saved_q;
    rem_d    = rem_q;
    pend_d   = pend_q;
    hold_d   = hold_q;
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    hex_d    = hex_q;
    cnt_d    = cnt_q;
    dstart_d = dstart_q;
    ovalid_d = ovalid_q && !out_ready_i;
    char_d   = char_q;
    last_d   = last_q;

    unique case (state_q)
      fsne_pkg::ST_IDLE: begin
        if (in_fire) begin
          saved_d = saved_eff;
          rem_d   = rem_eff;
          pend_d  = 1'b0;
          if (pend_eff) begin
            priority if (fmt_char_i == fsne_pkg::CharDec) begin
              rem_d = '0;
              if (rem_eff == '0) begin
                ovalid_d = 1'b1;
                char_d   = fsne_pkg::CharZero;
                last_d   = 1'b1;
              end else begin
                mag_d    = MagW'(mag_clamp);
                bcd_d    = '0;
                cnt_d    = CntW'(MagW - 1);
                dstart_d = 1'b0;
                state_d  = fsne_pkg::ST_CONV;
                if (rem_eff[31]) begin
                  ovalid_d = 1'b1;
                  char_d   = fsne_pkg::CharMinus;
                  last_d   = 1'b0;
                end
              end
            end else if (fmt_char_i == fsne_pkg::CharHex) begin
              ovalid_d = 1'b1;
              char_d   = fsne_pkg::CharZero;
              last_d   = 1'b0;
              hex_d    = saved_eff;
              state_d  = fsne_pkg::ST_HEX_X;
            end else begin
              ovalid_d = 1'b1;
              char_d   = fsne_pkg::CharPercent;
              last_d   = 1'b0;
              hold_d   = fmt_char_i;
              state_d  = fsne_pkg::ST_PCT_CHAR;
            end
          end else if (fmt_char_i == fsne_pkg::CharPercent) begin
            pend_d = 1'b1;
          end else begin
            ovalid_d = 1'b1;
            char_d   = fmt_char_i;
            last_d   = 1'b1;
          end
        end
      end
      fsne_pkg::ST_PCT_CHAR: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          char_d   = hold_q;
          last_d   = 1'b1;
          state_d  = fsne_pkg::ST_IDLE;
        end
      end
      fsne_pkg::ST_CONV: begin
        if (MagW > 1) begin
          bcd_d = {bcd_adj[BcdW-2:0], mag_q[MagW-1]};
        end else begin
          bcd_d = {bcd_adj[BcdW-2:0], mag_q[0]};
        end
        mag_d = mag_q << 1;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          cnt_d   = CntW'(DECIMAL_DIGITS - 1);
          state_d = fsne_pkg::ST_DIGIT;
        end
      end
      fsne_pkg::ST_DIGIT: begin
        if ((top_dig == 4'd0) && !dstart_q) begin
          bcd_d = bcd_q << 4;
          cnt_d = cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            state_d = fsne_pkg::ST_IDLE;
          end
        end else if (can_load) begin
          ovalid_d = 1'b1;
          char_d   = fsne_pkg::CharZero + {4'd0, top_dig};
          last_d   = (cnt_q == '0);
          dstart_d = 1'b1;
          bcd_d    = bcd_q << 4;
          cnt_d    = cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            state_d = fsne_pkg::ST_IDLE;
          end
        end
      end
      fsne_pkg::ST_HEX_X: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          char_d   = fsne_pkg::CharHex;
          last_d   = 1'b0;
          cnt_d    = CntW'(fsne_pkg::HexDigits - 1);
          state_d  = fsne_pkg::ST_HEX;
        end
      end
      fsne_pkg::ST_HEX: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          char_d   = (nib < 4'd10) ? (fsne_pkg::CharZero + {4'd0, nib})
                                   : (fsne_pkg::CharUpperA + {4'd0, nib - 4'd10});
          last_d   = (cnt_q == '0);
          hex_d    = hex_q << 4;
          cnt_d    = cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            state_d = fsne_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = fsne_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fsne_pkg::ST_IDLE;
      saved_q  <= '0;
      rem_q    <= '0;
      pend_q   <= 1'b0;
      cnt_q    <= '0;
      dstart_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      saved_q  <= saved_d;
      rem_q    <= rem_d;
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
      dstart_q <= dstart_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    hex_q  <= hex_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o   = ovalid_q;
  assign char_code_o   = char_q;
  assign last_in_run_o = last_q;

  assign busy    = (state_q != fsne_pkg::ST_IDLE);
  assign dig_end = (state_q == fsne_pkg::ST_DIGIT) && (cnt_q == '0) &&
                   ((top_dig != 4'd0) || dstart_q) && can_load;

  `FSNE_ASSERT(busy_blocks_input, busy |-> !in_ready_o, "input taken while busy")
  `FSNE_ASSERT(last_digit_ends_run, dig_end |=> !busy && last_q && ovalid_q, "last digit unmarked")
  `FSNE_ASSERT_ALWAYS(open_run_keeps_busy, ovalid_q && !last_q |-> busy, "run left open in idle")

endmodule
